// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMP(lbl, ck, rs, ant, con) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ant) |-> (con)) \
    else $error("implication check failed");

// Delayed implication, with the delay given by n, disabled while in reset
`define ASSERT_DLY(lbl, ck, rs, ant, n, con) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ant) |-> ##n (con)) \
    else $error("delayed check failed");

`endif

// ===== rtl/tslv_pkg.sv =====
package tslv_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_LIGHT_X = 2'd0;
  localparam logic [1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [1:0] REG_LIGHT_Z = 2'd2;

  localparam logic signed [15:0] LIGHT_X_RST = 16'sd0;
  localparam logic signed [15:0] LIGHT_Y_RST = 16'sd256;
  localparam logic signed [15:0] LIGHT_Z_RST = 16'sd256;

  // Unit length in Q1.14 and the width of the result magnitude
  localparam int UNIT_BITS = 15;
  localparam logic [UNIT_BITS-1:0] UNIT_ONE = 15'd16384;

  // Front stages, two per magnitude bit, one output stage
  localparam int FRONT_STAGES = 8;
  localparam int LATENCY = FRONT_STAGES + 2 * UNIT_BITS + 1;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic signed [15:0] tan_z;
    logic signed [15:0] bin_x;
    logic signed [15:0] bin_y;
    logic signed [15:0] bin_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
  } item_t;

  typedef struct packed {
    logic signed [15:0] light_t;
    logic signed [15:0] light_b;
    logic signed [15:0] light_n;
  } res_t;

  // State of one request inside the normalising chain
  typedef struct packed {
    logic                        valid;
    logic                        zero;
    logic [2:0]                  sg;
    logic [2:0][29:0]            msq;
    logic [31:0]                 s;
    logic [2:0][UNIT_BITS-1:0]   r;
    logic [UNIT_BITS-1:0]        t;
  } norm_t;

endpackage

// ===== rtl/tangent_space_light_vector.sv =====
// A taken start passes through the eight front stages (difference, products,
// sums, sign split, block shift, scaling, squares, sum of squares), then two
// stages per result bit in the divide-free square-root search, fifteen bits in
// all, and the output register, which raises done.
// Throughput: one vertex per cycle; busy stays low, start is never refused.
// Reset (rst, synchronous) empties the pipeline and reloads the light position.
`include "assert_macros.svh"

module tangent_space_light_vector (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tslv_pkg::item_t  item,
  output logic             done,
  output tslv_pkg::res_t   result,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import tslv_pkg::*;

  logic signed [15:0] light_x, light_y, light_z;
  norm_t chain [UNIT_BITS+1];
  norm_t fin;
  logic signed [15:0] o [3];
  logic out_ok;

  assign busy = 1'b0;

  // Light position registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= LIGHT_X_RST;
      light_y <= LIGHT_Y_RST;
      light_z <= LIGHT_Z_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIGHT_X: light_x <= cfg_data;
        REG_LIGHT_Y: light_y <= cfg_data;
        REG_LIGHT_Z: light_z <= cfg_data;
        default: ;
      endcase
    end
  end

  tslv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .item     (item),
    .light_x  (light_x),
    .light_y  (light_y),
    .light_z  (light_z),
    .norm     (chain[0])
  );

  // One search step per result bit, most significant first
  for (genvar g = 0; g < UNIT_BITS; g++) begin : g_step
    tslv_step u_step (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  assign fin = chain[UNIT_BITS];

  // Apply signs, force zero for a zero-length vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fin.zero) o[i] = '0;
      else if (fin.sg[i]) o[i] = -16'(fin.r[i]);
      else o[i] = 16'(fin.r[i]);
    end
  end

  always_ff @(posedge clk) begin
    done <= fin.valid;
    result.light_t <= o[0];
    result.light_b <= o[1];
    result.light_n <= o[2];
    if (rst) done <= 1'b0;
  end

  // Every output component lies within unit length
  assign out_ok = (result.light_t >= -16'sd16384) && (result.light_t <= 16'sd16384) &&
                  (result.light_b >= -16'sd16384) && (result.light_b <= 16'sd16384) &&
                  (result.light_n >= -16'sd16384) && (result.light_n <= 16'sd16384);

  `ASSERT_DLY(a_no_loss, clk, rst, start && !busy, LATENCY, done)
  `ASSERT_IMP(a_out_range, clk, rst, done, out_ok)

endmodule

// ===== rtl/tslv_front.sv =====
module tslv_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  tslv_pkg::item_t         item,
  input  logic signed [15:0]      light_x,
  input  logic signed [15:0]      light_y,
  input  logic signed [15:0]      light_z,
  output tslv_pkg::norm_t         norm
);
  import tslv_pkg::*;

  logic v1, v2, v3, v4, v5, v6, v7;
  logic signed [16:0] dv [3];
  logic signed [15:0] u1 [9];
  logic signed [32:0] pr [9];
  logic signed [34:0] p [3];
  logic [34:0] mag4 [3];
  logic [2:0] sg4, sg5, sg6, sg7;
  logic zero4, zero5, zero6, zero7;
  logic [34:0] orv;
  logic [34:0] mag5 [3];
  logic [4:0] sh5;
  logic [5:0] blen;
  logic [4:0] sh_next;
  logic [14:0] m6 [3];
  logic [29:0] msq7 [3];

  // Form the light direction and hold the basis
  always_ff @(posedge clk) begin
    v1 <= in_valid;
    dv[0] <= {light_x[15], light_x} - {item.pos_x[15], item.pos_x};
    dv[1] <= {light_y[15], light_y} - {item.pos_y[15], item.pos_y};
    dv[2] <= {light_z[15], light_z} - {item.pos_z[15], item.pos_z};
    u1[0] <= item.tan_x; u1[1] <= item.tan_y; u1[2] <= item.tan_z;
    u1[3] <= item.bin_x; u1[4] <= item.bin_y; u1[5] <= item.bin_z;
    u1[6] <= item.nrm_x; u1[7] <= item.nrm_y; u1[8] <= item.nrm_z;
    if (rst) v1 <= 1'b0;
  end

  // Nine partial products
  always_ff @(posedge clk) begin
    v2 <= v1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pr[3*i+j] <= dv[j] * u1[3*i+j];
      end
    end
    if (rst) v2 <= 1'b0;
  end

  // Sum into the three dot products
  always_ff @(posedge clk) begin
    v3 <= v2;
    for (int i = 0; i < 3; i++) begin
      p[i] <= 35'(pr[3*i]) + 35'(pr[3*i+1]) + 35'(pr[3*i+2]);
    end
    if (rst) v3 <= 1'b0;
  end

  // Split into sign and magnitude
  always_ff @(posedge clk) begin
    v4 <= v3;
    for (int i = 0; i < 3; i++) begin
      sg4[i] <= p[i][34];
      mag4[i] <= p[i][34] ? 35'(-p[i]) : p[i];
    end
    if (rst) v4 <= 1'b0;
  end

  // Find the block shift from the top set bit of all magnitudes
  always_comb begin
    orv = mag4[0] | mag4[1] | mag4[2];
    blen = 6'd0;
    for (int b = 0; b < 35; b++) begin
      if (orv[b]) blen = 6'(b + 1);
    end
    sh_next = (blen > 6'd15) ? 5'(blen - 6'd15) : 5'd0;
    zero4 = (orv == 35'd0);
  end

  always_ff @(posedge clk) begin
    v5 <= v4;
    sh5 <= sh_next;
    sg5 <= sg4;
    zero5 <= zero4;
    mag5 <= mag4;
    if (rst) v5 <= 1'b0;
  end

  // Scale the magnitudes to 15 bits
  always_ff @(posedge clk) begin
    v6 <= v5;
    sg6 <= sg5;
    zero6 <= zero5;
    for (int i = 0; i < 3; i++) begin
      m6[i] <= 15'(mag5[i] >> sh5);
    end
    if (rst) v6 <= 1'b0;
  end

  // Square each magnitude
  always_ff @(posedge clk) begin
    v7 <= v6;
    sg7 <= sg6;
    zero7 <= zero6;
    for (int i = 0; i < 3; i++) begin
      msq7[i] <= m6[i] * m6[i];
    end
    if (rst) v7 <= 1'b0;
  end

  // Sum of squares and hand over to the normalising chain
  always_ff @(posedge clk) begin
    norm.valid <= v7;
    norm.zero <= zero7;
    norm.sg <= sg7;
    for (int i = 0; i < 3; i++) begin
      norm.msq[i] <= msq7[i];
      norm.r[i] <= '0;
    end
    norm.s <= 32'(msq7[0]) + 32'(msq7[1]) + 32'(msq7[2]);
    norm.t <= UNIT_BITS'(1) << (UNIT_BITS - 1);
    if (rst) norm.valid <= 1'b0;
  end

endmodule

// ===== rtl/tslv_step.sv =====
`include "assert_macros.svh"

module tslv_step (
  input  logic             clk,
  input  logic             rst,
  input  tslv_pkg::norm_t  din,
  output tslv_pkg::norm_t  dout
);
  import tslv_pkg::*;

  tslv_pkg::norm_t mid;
  logic [2:0][UNIT_BITS-1:0] c, cm;
  logic [2:0] skip, skipm;
  logic [15:0] k [3];
  logic [31:0] ksq [3];
  logic [63:0] prod [3];
  logic [63:0] rhs [3];
  logic r_ok;

  // Trial value with the next bit set and its squared odd bound
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c[i] = din.r[i] | din.t;
      skip[i] = (c[i] > UNIT_ONE);
      k[i] = {c[i], 1'b0} - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    mid <= din;
    cm <= c;
    skipm <= skip;
    for (int i = 0; i < 3; i++) begin
      ksq[i] <= k[i] * k[i];
    end
    if (rst) mid.valid <= 1'b0;
  end

  // Compare against the scaled square and keep the bit when it fits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = ksq[i] * mid.s;
      rhs[i] = {4'd0, mid.msq[i], 30'd0};
    end
  end

  always_ff @(posedge clk) begin
    dout <= mid;
    dout.t <= mid.t >> 1;
    for (int i = 0; i < 3; i++) begin
      if (!skipm[i] && (prod[i] <= rhs[i])) dout.r[i] <= cm[i];
    end
    if (rst) dout.valid <= 1'b0;
  end

  // Every partial magnitude stays within unit length
  assign r_ok = (dout.r[0] <= UNIT_ONE) && (dout.r[1] <= UNIT_ONE) &&
                (dout.r[2] <= UNIT_ONE);

  `ASSERT_IMP(a_r_bound, clk, rst, dout.valid, r_ok)

endmodule
